[sv/bdsw_pkg.sv]
`default_nettype none
package bdsw_pkg;

	localparam int unsigned BASE_W = 12;
	localparam int unsigned YEAR_W = 7;
	localparam int unsigned CFG_W  = 12;
	localparam int unsigned FULL_W = 13;

	localparam logic [BASE_W-1:0] YEAR_BASE_RST = 12'd2000;
	localparam logic [YEAR_W-1:0] YEAR_LO_RST   = 7'd0;
	localparam logic [YEAR_W-1:0] YEAR_HI_RST   = 7'd99;

	// keeps the Gregorian arithmetic non-negative for any base
	localparam logic [FULL_W-1:0] CYCLE_YEARS = 13'd400;

	// reciprocal constants: x/100 for x < 43690, x/7 for x < 43690
	localparam logic [12:0] RECIP_100 = 13'd5243;
	localparam logic [15:0] RECIP_7   = 16'd37450;

	typedef enum logic [1:0] {
		REG_YEAR_BASE = 2'd0,
		REG_YEAR_LO   = 2'd1,
		REG_YEAR_HI   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] sec_bcd;
		logic [7:0] min_bcd;
		logic [7:0] hour_bcd;
		logic [7:0] day_bcd;
		logic [7:0] month_bcd;
		logic [7:0] year_bcd;
	} in_item_t;

	typedef struct packed {
		logic [6:0] sec_out;
		logic [6:0] min_out;
		logic [5:0] hour_out;
		logic [5:0] day_out;
		logic [4:0] month_out;
		logic [7:0] year_out;
		logic [2:0] weekday;
	} out_item_t;

	localparam logic [2:0] MONTH_OFF [12] = '{
		3'd0, 3'd3, 3'd2, 3'd5, 3'd0, 3'd3, 3'd5, 3'd1, 3'd4, 3'd6, 3'd2, 3'd4
	};

	function automatic logic [7:0] bcd_decode(input logic [7:0] b);
		logic [7:0] hi10;
		begin
			hi10 = {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0};
			return hi10 + {4'd0, b[3:0]};
		end
	endfunction

	// value is below 128; wrap to two digits first
	function automatic logic [7:0] bcd_encode(input logic [6:0] v);
		logic [6:0]  v2;
		logic [17:0] prod;
		logic [3:0]  tens;
		logic [6:0]  ones;
		begin
			v2   = (v >= 7'd100) ? v - 7'd100 : v;
			prod = {11'd0, v2} * 18'd205;
			tens = prod[14:11];
			ones = v2 - ({3'd0, tens} * 7'd10);
			return {tens, ones[3:0]};
		end
	endfunction

endpackage
`default_nettype wire

[sv/bdsw_chan_if.sv]
`default_nettype none
interface bdsw_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/bcd_datetime_sanitize_weekday.sv]
// BCD date-time sanitizer with day-of-week.
// din (bdsw_chan_if of bdsw_pkg::in_item_t) carries six raw RTC BCD bytes;
// dout (bdsw_chan_if of bdsw_pkg::out_item_t) returns one item per input:
// range-checked canonical BCD fields (bad fields replaced by their minimum)
// and the weekday, 0 = Sunday, from year_base + year.
// Configuration: cfg_we/cfg_idx/cfg_data, index 0 year_base, 1 lower year
// limit, 2 upper year limit; write only while no item is in flight.
// Throughput: one item per cycle while dout.ready is high. Stages: decode,
// check/encode/year sum, /100 multiply, Sakamoto sum, /7 multiply, remainder.
// The two reciprocal multiplies set the depth.
// Each stage has its own valid bit and advances when empty or when the
// next one moves, so bubbles collapse; when dout stalls the pipe fills and
// din.ready drops only once all six stages hold items. Nothing is lost.
// Reset (arst_n low) empties the pipe and loads year_base 2000, lower year
// limit 0, upper year limit 99.
`default_nettype none
module bcd_datetime_sanitize_weekday (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [1:0]               cfg_idx,
	input  wire logic [bdsw_pkg::CFG_W-1:0] cfg_data,
	bdsw_chan_if.sink                     din,
	bdsw_chan_if.source                   dout
);
	import bdsw_pkg::*;

	logic [BASE_W-1:0] year_base_q;
	logic [YEAR_W-1:0] year_lo_q;
	logic [YEAR_W-1:0] year_hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_base_q <= YEAR_BASE_RST;
			year_lo_q   <= YEAR_LO_RST;
			year_hi_q   <= YEAR_HI_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_YEAR_BASE: year_base_q <= cfg_data[BASE_W-1:0];
				REG_YEAR_LO:   year_lo_q   <= cfg_data[YEAR_W-1:0];
				REG_YEAR_HI:   year_hi_q   <= cfg_data[YEAR_W-1:0];
				default: ;
			endcase
		end
	end

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;

	assign en6 = !v_s6 || dout.ready;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign din.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= din.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// stage 1: decode
	logic [7:0] sec_s1, min_s1, hour_s1, day_s1, mon_s1, year_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			sec_s1  <= bcd_decode(din.data.sec_bcd);
			min_s1  <= bcd_decode(din.data.min_bcd);
			hour_s1 <= bcd_decode(din.data.hour_bcd);
			day_s1  <= bcd_decode(din.data.day_bcd);
			mon_s1  <= bcd_decode(din.data.month_bcd);
			year_s1 <= bcd_decode(din.data.year_bcd);
		end
	end

	// stage 2: check, replace, encode; full year and month offset + day
	logic [6:0] sec_c, min_c, hour_c, day_c, mon_c, year_c;
	logic [3:0] mon_idx;
	logic [FULL_W-1:0] yy_c;
	logic [5:0] offd_c;

	always_comb begin
		sec_c  = (sec_s1 < 8'd60) ? sec_s1[6:0] : 7'd0;
		min_c  = (min_s1 < 8'd60) ? min_s1[6:0] : 7'd0;
		hour_c = (hour_s1 < 8'd24) ? hour_s1[6:0] : 7'd0;
		day_c  = (day_s1 >= 8'd1 && day_s1 <= 8'd31) ? day_s1[6:0] : 7'd1;
		mon_c  = (mon_s1 >= 8'd1 && mon_s1 <= 8'd12) ? mon_s1[6:0] : 7'd1;
		year_c = (year_s1 < {1'b0, year_lo_q} || year_s1 > {1'b0, year_hi_q})
			? year_lo_q : year_s1[6:0];
		mon_idx = mon_c[3:0] - 4'd1;
		yy_c = {1'b0, year_base_q} + {6'd0, year_c} + CYCLE_YEARS
			- {12'd0, (mon_c < 7'd3)};
		offd_c = {3'd0, MONTH_OFF[mon_idx]} + day_c[5:0];
	end

	logic [6:0] sec_s2, min_s2;
	logic [5:0] hour_s2, day_s2;
	logic [4:0] mon_s2;
	logic [7:0] year_s2;
	logic [FULL_W-1:0] yy_s2;
	logic [5:0] offd_s2;
	logic [7:0] sec_e, min_e, hour_e, day_e, mon_e;

	always_comb begin
		sec_e  = bcd_encode(sec_c);
		min_e  = bcd_encode(min_c);
		hour_e = bcd_encode(hour_c);
		day_e  = bcd_encode(day_c);
		mon_e  = bcd_encode(mon_c);
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			sec_s2  <= sec_e[6:0];
			min_s2  <= min_e[6:0];
			hour_s2 <= hour_e[5:0];
			day_s2  <= day_e[5:0];
			mon_s2  <= mon_e[4:0];
			year_s2 <= bcd_encode(year_c);
			yy_s2   <= yy_c;
			offd_s2 <= offd_c;
		end
	end

	// stage 3: yy / 100
	logic [25:0] p100;
	assign p100 = {13'd0, yy_s2} * {13'd0, RECIP_100};

	logic [6:0] sec_s3, min_s3;
	logic [5:0] hour_s3, day_s3;
	logic [4:0] mon_s3;
	logic [7:0] year_s3;
	logic [FULL_W-1:0] yy_s3;
	logic [5:0] offd_s3;
	logic [5:0] q100_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			sec_s3  <= sec_s2;
			min_s3  <= min_s2;
			hour_s3 <= hour_s2;
			day_s3  <= day_s2;
			mon_s3  <= mon_s2;
			year_s3 <= year_s2;
			yy_s3   <= yy_s2;
			offd_s3 <= offd_s2;
			q100_s3 <= p100[24:19];
		end
	end

	// stage 4: Sakamoto sum, yy/400 taken as (yy/100)/4
	logic [13:0] sum_c;
	assign sum_c = {1'b0, yy_s3} + {3'd0, yy_s3[FULL_W-1:2]} - {8'd0, q100_s3}
		+ {10'd0, q100_s3[5:2]} + {8'd0, offd_s3};

	logic [6:0] sec_s4, min_s4;
	logic [5:0] hour_s4, day_s4;
	logic [4:0] mon_s4;
	logic [7:0] year_s4;
	logic [FULL_W-1:0] sum_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			sec_s4  <= sec_s3;
			min_s4  <= min_s3;
			hour_s4 <= hour_s3;
			day_s4  <= day_s3;
			mon_s4  <= mon_s3;
			year_s4 <= year_s3;
			sum_s4  <= sum_c[FULL_W-1:0];
		end
	end

	// stage 5: sum / 7
	logic [28:0] p7;
	assign p7 = {16'd0, sum_s4} * {13'd0, RECIP_7};

	logic [6:0] sec_s5, min_s5;
	logic [5:0] hour_s5, day_s5;
	logic [4:0] mon_s5;
	logic [7:0] year_s5;
	logic [FULL_W-1:0] sum_s5;
	logic [9:0] q7_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			sec_s5  <= sec_s4;
			min_s5  <= min_s4;
			hour_s5 <= hour_s4;
			day_s5  <= day_s4;
			mon_s5  <= mon_s4;
			year_s5 <= year_s4;
			sum_s5  <= sum_s4;
			q7_s5   <= p7[27:18];
		end
	end

	// stage 6: remainder, output register
	logic [FULL_W-1:0] rem_c;
	assign rem_c = sum_s5 - ({3'd0, q7_s5} * 13'd7);

	out_item_t out_s6;

	always_ff @(posedge clk) begin
		if (en6) begin
			out_s6.sec_out   <= sec_s5;
			out_s6.min_out   <= min_s5;
			out_s6.hour_out  <= hour_s5;
			out_s6.day_out   <= day_s5;
			out_s6.month_out <= mon_s5;
			out_s6.year_out  <= year_s5;
			out_s6.weekday   <= rem_c[2:0];
		end
	end

	assign dout.valid = v_s6;
	assign dout.data  = out_s6;

endmodule
`default_nettype wire

[test/bcd_datetime_sanitize_weekday_test.sv]
`default_nettype none
module bcd_datetime_sanitize_weekday_test;
	timeunit 1ns;
	timeprecision 1ps;

	import bdsw_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int unsigned MONTH_SHIFT [12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [1:0]        cfg_idx;
	logic [CFG_W-1:0]  cfg_data;

	bdsw_chan_if #(.T(in_item_t))  in_ch ();
	bdsw_chan_if #(.T(out_item_t)) out_ch ();

	bcd_datetime_sanitize_weekday dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.din      (in_ch),
		.dout     (out_ch)
	);

	// register copies used for prediction
	logic [BASE_W-1:0] base_year;
	logic [YEAR_W-1:0] lo_year;
	logic [YEAR_W-1:0] hi_year;

	in_item_t  pending [$];
	out_item_t expected [$];

	int mismatches = 0;
	int items_in = 0;
	int send_gap = 0;
	int recv_gap = 0;
	int hold_left = 0;
	int holds_done = 0;
	int stuck = 0;
	bit steady = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned bcd_value(input logic [7:0] b);
		return b[7:4] * 10 + b[3:0];
	endfunction

	function automatic logic [7:0] to_bcd(input int unsigned v);
		int unsigned w;
		w = v % 100;
		return {4'(w / 10), 4'(w % 10)};
	endfunction

	// nibble-wise packing, tens digit may exceed nine (v < 160)
	function automatic logic [7:0] pack_dec(input int unsigned v);
		return {4'(v / 10), 4'(v % 10)};
	endfunction

	function automatic out_item_t sanitize_datetime(input in_item_t raw);
		out_item_t   o;
		int unsigned s, mi, h, d, mo, y, yy;
		s  = bcd_value(raw.sec_bcd);
		mi = bcd_value(raw.min_bcd);
		h  = bcd_value(raw.hour_bcd);
		d  = bcd_value(raw.day_bcd);
		mo = bcd_value(raw.month_bcd);
		y  = bcd_value(raw.year_bcd);
		if (s >= 60) s = 0;
		if (mi >= 60) mi = 0;
		if (h >= 24) h = 0;
		if (d < 1 || d > 31) d = 1;
		if (mo < 1 || mo > 12) mo = 1;
		if (y < lo_year || y > hi_year) y = lo_year;
		o.sec_out   = 7'(to_bcd(s));
		o.min_out   = 7'(to_bcd(mi));
		o.hour_out  = 6'(to_bcd(h));
		o.day_out   = 6'(to_bcd(d));
		o.month_out = 5'(to_bcd(mo));
		o.year_out  = to_bcd(y);
		// Sakamoto, shifted by 400 years so the sum never goes negative
		yy = base_year + y + 400;
		if (mo < 3) yy--;
		o.weekday = 3'((yy + yy / 4 - yy / 100 + yy / 400 + MONTH_SHIFT[mo - 1] + d) % 7);
		return o;
	endfunction

	function automatic in_item_t datetime(input logic [7:0] s, mi, h, d, mo, y);
		in_item_t t;
		t.sec_bcd   = s;
		t.min_bcd   = mi;
		t.hour_bcd  = h;
		t.day_bcd   = d;
		t.month_bcd = mo;
		t.year_bcd  = y;
		return t;
	endfunction

	function automatic int unsigned pick(input int unsigned lo, input int unsigned hi);
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0) return lo;
		if (r == 1) return hi;
		return $urandom_range(hi, lo);
	endfunction

	function automatic in_item_t random_datetime();
		in_item_t    t;
		int unsigned r, y;
		r = $urandom_range(0, 99);
		if (lo_year <= hi_year) y = pick(lo_year, hi_year);
		else y = $urandom_range(0, 159);
		t = datetime(pack_dec(pick(0, 59)), pack_dec(pick(0, 59)), pack_dec(pick(0, 23)),
			pack_dec(pick(1, 31)), pack_dec(pick(1, 12)), pack_dec(y));
		if (r >= 88) begin
			t = 48'({$urandom, $urandom});
		end else if (r >= 68) begin
			case ($urandom_range(0, 5))
				0: t.sec_bcd = 8'($urandom);
				1: t.min_bcd = 8'($urandom);
				2: t.hour_bcd = 8'($urandom);
				3: t.day_bcd = 8'($urandom);
				4: t.month_bcd = 8'($urandom);
				default: t.year_bcd = 8'($urandom);
			endcase
		end
		return t;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int idle_len();
		int unsigned r;
		if (steady) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic void check_field(input string tag, input logic [7:0] want, got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t %s: expected %0h, got %0h", $time, tag, want, got);
		end
	endfunction

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				expected.push_back(sanitize_datetime(in_ch.data));
				items_in <= items_in + 1;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (send_gap != 0) begin
					send_gap--;
					in_ch.valid <= 1'b0;
				end else if (pending.size() != 0) begin
					in_ch.data <= pending.pop_front();
					in_ch.valid <= 1'b1;
					send_gap = idle_len();
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-offs so the pipe fills and din.ready drops
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if ((holds_done == 0 && items_in >= 150) ||
				(holds_done == 1 && items_in >= 420)) begin
			hold_left <= 80;
			holds_done <= holds_done + 1;
		end
	end

	// monitor
	always @(posedge clk) begin
		out_item_t want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t unexpected item %p", $time, out_ch.data);
				end else begin
					want = expected.pop_front();
					check_field("sec_out", want.sec_out, out_ch.data.sec_out);
					check_field("min_out", want.min_out, out_ch.data.min_out);
					check_field("hour_out", want.hour_out, out_ch.data.hour_out);
					check_field("day_out", want.day_out, out_ch.data.day_out);
					check_field("month_out", want.month_out, out_ch.data.month_out);
					check_field("year_out", want.year_out, out_ch.data.year_out);
					check_field("weekday", want.weekday, out_ch.data.weekday);
				end
			end
			if (hold_left != 0) begin
				out_ch.ready <= 1'b0;
			end else if (recv_gap != 0) begin
				recv_gap--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				recv_gap = idle_len();
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			stuck <= 0;
		end else if (stuck == STALL_LIMIT) begin
			$display("%0t no progress, %0d items outstanding", $time, expected.size());
			$display("[bcd_datetime_sanitize_weekday] ERROR");
			$finish;
		end else begin
			stuck <= stuck + 1;
		end
	end

	task automatic wait_drained();
		do @(negedge clk);
		while (pending.size() != 0 || in_ch.valid || expected.size() != 0);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_YEAR_BASE: base_year = val[BASE_W-1:0];
			REG_YEAR_LO: lo_year = val[YEAR_W-1:0];
			default: hi_year = val[YEAR_W-1:0];
		endcase
	endtask

	task automatic run_phase(input logic [BASE_W-1:0] base, input logic [YEAR_W-1:0] lo, hi,
			input bit calm, input int count);
		repeat (8) @(posedge clk);
		write_reg(REG_YEAR_BASE, base);
		write_reg(REG_YEAR_LO, CFG_W'(lo));
		write_reg(REG_YEAR_HI, CFG_W'(hi));
		@(negedge clk);
		steady = calm;
		repeat (count) pending.push_back(random_datetime());
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_YEAR_BASE;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		base_year = YEAR_BASE_RST;
		lo_year = YEAR_LO_RST;
		hi_year = YEAR_HI_RST;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		pending.push_back(datetime(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		pending.push_back(datetime(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99));
		pending.push_back(datetime(8'h60, 8'h60, 8'h24, 8'h32, 8'h13, 8'hA0));
		pending.push_back(datetime(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		// nibbles above nine decode arithmetically
		pending.push_back(datetime(8'h1A, 8'h0F, 8'h1F, 8'h0A, 8'h0B, 8'h9F));
		pending.push_back(datetime(8'h3F, 8'h4E, 8'h0E, 8'h1C, 8'h0A, 8'h8F));
		// day past the end of its month
		pending.push_back(datetime(8'h00, 8'h00, 8'h00, 8'h31, 8'h02, 8'h24));
		pending.push_back(datetime(8'h30, 8'h30, 8'h12, 8'h31, 8'h04, 8'h23));
		// January/February use the previous year
		pending.push_back(datetime(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00));
		pending.push_back(datetime(8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h00));
		pending.push_back(datetime(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00));
		pending.push_back(datetime(8'h00, 8'h00, 8'h00, 8'h28, 8'h02, 8'h01));
		pending.push_back(datetime(8'h55, 8'h55, 8'h55, 8'h55, 8'h55, 8'h55));
		pending.push_back(datetime(8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'hAA));
		pending.push_back(datetime(8'h09, 8'h90, 8'h19, 8'h30, 8'h10, 8'h01));
		pending.push_back(datetime(8'h59, 8'h00, 8'h00, 8'h01, 8'h01, 8'h99));
		wait_drained();

		run_phase(12'd1753, 7'd0, 7'd99, 1'b0, 80);
		// years 100..127 accepted: year_out wraps, weekday uses the full value
		run_phase(12'd0, 7'd0, 7'd127, 1'b0, 80);
		run_phase(12'd4095, 7'd100, 7'd127, 1'b0, 80);
		// empty window: every year falls back to the lower limit
		run_phase(12'd2000, 7'd50, 7'd20, 1'b0, 60);
		run_phase(12'd1970, 7'd70, 7'd99, 1'b1, 90);
		run_phase(12'd2048, 7'd127, 7'd127, 1'b0, 60);
		run_phase(12'($urandom_range(0, 4095)), 7'd0, 7'd0, 1'b0, 30);
		run_phase(12'd2000, 7'd0, 7'd99, 1'b0, 90);

		repeat (10) @(posedge clk);
		if (mismatches == 0 && expected.size() == 0)
			$display("[bcd_datetime_sanitize_weekday] OK");
		else
			$display("[bcd_datetime_sanitize_weekday] ERROR");
		$finish;
	end

endmodule
`default_nettype wire
